### rtl/core/bmpd_pkg.sv
`default_nettype none

package bmpd_pkg;

    localparam logic [1:0] KIND_CHANNEL  = 2'd0;
    localparam logic [1:0] KIND_SYSCOM   = 2'd1;
    localparam logic [1:0] KIND_REALTIME = 2'd2;
    localparam logic [1:0] KIND_SYSEX    = 2'd3;

    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [7:0] REALTIME_MIN  = 8'hF8;
    localparam logic [7:0] SONG_POSITION = 8'hF2;
    localparam logic [7:0] TIME_CODE_QF  = 8'hF1;
    localparam logic [7:0] SONG_SELECT   = 8'hF3;
    localparam logic [3:0] PROG_CHANGE   = 4'hC;
    localparam logic [3:0] CHAN_PRESSURE = 4'hD;
    localparam logic [1:0] HEADER_TAG    = 2'b10;

    typedef struct packed {
        logic [7:0]  byte_zero;
        logic [6:0]  byte_one;
        logic [6:0]  byte_two;
        logic [1:0]  length;
        logic [1:0]  kind;
        logic [12:0] stamp;
    } msg_t;

    // total length of a system common / real time message
    function automatic logic [1:0] sys_len(input logic [7:0] status);
        logic [1:0] len;
        len = 2'd1;
        if (status == TIME_CODE_QF || status == SONG_SELECT)
            len = 2'd2;
        else if (status == SONG_POSITION)
            len = 2'd3;
        return len;
    endfunction

    function automatic msg_t make_msg(input logic [7:0] b0, input logic [6:0] b1,
                                      input logic [6:0] b2, input logic [1:0] len,
                                      input logic [1:0] kind, input logic [12:0] stamp);
        msg_t m;
        m.byte_zero = b0;
        m.byte_one  = (len >= 2'd2) ? b1 : 7'd0;
        m.byte_two  = (len == 2'd3) ? b2 : 7'd0;
        m.length    = len;
        m.kind      = kind;
        m.stamp     = stamp;
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bmpd_if.sv
`default_nettype none

interface bmpd_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       packet_end;

    modport source (output valid, output packet_byte, output packet_end, input ready);
    modport sink (input valid, input packet_byte, input packet_end, output ready);
endinterface

interface bmpd_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_byte_zero;
    logic [6:0]  msg_byte_one;
    logic [6:0]  msg_byte_two;
    logic [1:0]  msg_length;
    logic [1:0]  msg_kind;
    logic [12:0] msg_time;
    logic        run_last;

    modport source (output valid, output msg_byte_zero, output msg_byte_one,
                    output msg_byte_two, output msg_length, output msg_kind,
                    output msg_time, output run_last, input ready);
    modport sink (input valid, input msg_byte_zero, input msg_byte_one,
                  input msg_byte_two, input msg_length, input msg_kind,
                  input msg_time, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/core/ble_midi_packet_decoder.sv
// A message shows on msg in the cycle after the packet byte that completes it.
// Throughput: one packet byte per cycle; each byte yields at most one message word.
// Input stalls while a finished word waits in the output register and msg is not ready.
// Reset (rst_n low, asynchronous): parser expects a header, all timing and
// running-status state cleared, output register empty.
`default_nettype none

module ble_midi_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    bmpd_pkt_if.sink    pkt,
    bmpd_msg_if.source  msg
);
    import bmpd_pkg::*;

    logic  take;
    logic  emit;
    msg_t  result;
    msg_t  msg_reg;
    logic  valid_reg;

    assign pkt.ready = !valid_reg || msg.ready;
    assign take      = pkt.valid && pkt.ready;

    bmpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .packet_byte (pkt.packet_byte),
        .packet_end  (pkt.packet_end),
        .emit        (emit),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take && emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (msg.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            msg_reg <= result;
        end
    end

    assign msg.valid         = valid_reg;
    assign msg.msg_byte_zero = msg_reg.byte_zero;
    assign msg.msg_byte_one  = msg_reg.byte_one;
    assign msg.msg_byte_two  = msg_reg.byte_two;
    assign msg.msg_length    = msg_reg.length;
    assign msg.msg_kind      = msg_reg.kind;
    assign msg.msg_time      = msg_reg.stamp;
    assign msg.run_last      = 1'b1;   // one word per byte at most

endmodule

`default_nettype wire

### rtl/core/bmpd_parser.sv
`default_nettype none

module bmpd_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      packet_byte,
    input  logic            packet_end,
    output logic            emit,
    output bmpd_pkg::msg_t  result
);
    import bmpd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FIRST,
        PH_START,
        PH_TS,
        PH_RUNHELD,
        PH_COLLECT,
        PH_SYSEX
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [5:0]  time_high_reg, time_high_next;   // bits 12..7 of the time
    logic [7:0]  prev_low_reg, prev_low_next;
    logic [7:0]  run_status_reg, run_status_next;
    logic [1:0]  run_length_reg, run_length_next;
    logic [7:0]  cur_b0_reg, cur_b0_next;
    logic [6:0]  cur_b1_reg, cur_b1_next;
    logic [6:0]  cur_b2_reg, cur_b2_next;
    logic [1:0]  cur_count_reg, cur_count_next;
    logic [1:0]  cur_kind_reg, cur_kind_next;
    logic [12:0] cur_time_reg, cur_time_next;
    logic        in_sysex_reg, in_sysex_next;
    logic        drop_rest_reg, drop_rest_next;

    logic [5:0]  th_adv;
    logic [12:0] ts;
    logic [1:0]  cnt_inc;
    logic [7:0]  nb0;
    logic [6:0]  nb1;
    logic [6:0]  nb2;
    logic [1:0]  target;
    logic [3:0]  hi_nibble;

    // timestamp byte lower than the previous one: high part rolls over
    assign th_adv    = time_high_reg + {5'd0, (prev_low_reg > held_byte_reg)};
    assign ts        = {th_adv, held_byte_reg[6:0]};
    assign cnt_inc   = cur_count_reg + 2'd1;
    assign nb0       = (cur_count_reg == 2'd0) ? packet_byte : cur_b0_reg;
    assign nb1       = (cur_count_reg == 2'd1) ? packet_byte[6:0] : cur_b1_reg;
    assign nb2       = (cur_count_reg == 2'd2) ? packet_byte[6:0] : cur_b2_reg;
    assign target    = (cur_kind_reg == KIND_CHANNEL) ? run_length_reg : sys_len(nb0);
    assign hi_nibble = packet_byte[7:4];

    always_comb
    begin
        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        time_high_next  = time_high_reg;
        prev_low_next   = prev_low_reg;
        run_status_next = run_status_reg;
        run_length_next = run_length_reg;
        cur_b0_next     = cur_b0_reg;
        cur_b1_next     = cur_b1_reg;
        cur_b2_next     = cur_b2_reg;
        cur_count_next  = cur_count_reg;
        cur_kind_next   = cur_kind_reg;
        cur_time_next   = cur_time_reg;
        in_sysex_next   = in_sysex_reg;
        drop_rest_next  = drop_rest_reg;
        emit            = 1'b0;
        result          = '0;

        if (take)
        begin
            if (!drop_rest_reg)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (!packet_end)
                        begin
                            if (packet_byte[7:6] != HEADER_TAG)
                            begin
                                drop_rest_next = 1'b1;
                            end
                            else
                            begin
                                held_byte_next  = '0;
                                time_high_next  = packet_byte[5:0];
                                prev_low_next   = '0;
                                run_status_next = '0;
                                run_length_next = '0;
                                cur_b0_next     = '0;
                                cur_b1_next     = '0;
                                cur_b2_next     = '0;
                                cur_count_next  = '0;
                                cur_kind_next   = KIND_CHANNEL;
                                cur_time_next   = '0;
                                in_sysex_next   = 1'b0;
                                phase_next      = PH_FIRST;
                            end
                        end
                    end
                    PH_FIRST:
                    begin
                        if (!packet_byte[7])
                        begin
                            // sysex continued from the previous packet
                            in_sysex_next  = 1'b1;
                            cur_kind_next  = KIND_SYSEX;
                            cur_time_next  = {time_high_reg, 7'd0};
                            cur_b0_next    = packet_byte;
                            cur_b1_next    = '0;
                            cur_b2_next    = '0;
                            cur_count_next = 2'd1;
                            phase_next     = PH_SYSEX;
                        end
                        else
                        begin
                            held_byte_next = packet_byte;
                            phase_next     = PH_TS;
                        end
                    end
                    PH_START:
                    begin
                        if (packet_byte[7])
                        begin
                            held_byte_next = packet_byte;
                            phase_next     = PH_TS;
                        end
                        else if (cur_kind_reg != KIND_CHANNEL || run_status_reg == 8'd0
                                 || in_sysex_reg)
                        begin
                            drop_rest_next = 1'b1;
                        end
                        else if (run_length_reg == 2'd3)
                        begin
                            cur_b0_next    = run_status_reg;
                            cur_b1_next    = packet_byte[6:0];
                            cur_b2_next    = '0;
                            cur_count_next = 2'd2;
                            phase_next     = PH_COLLECT;
                        end
                        else
                        begin
                            held_byte_next = packet_byte;
                            phase_next     = PH_RUNHELD;
                        end
                    end
                    PH_TS:
                    begin
                        if (!packet_byte[7])
                        begin
                            if (run_status_reg == 8'd0)
                            begin
                                drop_rest_next = 1'b1;
                            end
                            else
                            begin
                                time_high_next = th_adv;
                                prev_low_next  = held_byte_reg;
                                cur_time_next  = ts;
                                in_sysex_next  = 1'b0;
                                cur_kind_next  = KIND_CHANNEL;
                                cur_b0_next    = run_status_reg;
                                cur_b1_next    = packet_byte[6:0];
                                cur_b2_next    = '0;
                                cur_count_next = 2'd2;
                                if (run_length_reg == 2'd2)
                                begin
                                    emit       = 1'b1;
                                    result     = make_msg(run_status_reg, packet_byte[6:0],
                                                          7'd0, 2'd2, KIND_CHANNEL, ts);
                                    phase_next = PH_START;
                                end
                                else
                                begin
                                    phase_next = PH_COLLECT;
                                end
                            end
                        end
                        else if (in_sysex_reg)
                        begin
                            if (packet_byte >= REALTIME_MIN)
                            begin
                                // real time inside sysex, chunk time stays
                                time_high_next = th_adv;
                                prev_low_next  = held_byte_reg;
                                emit           = 1'b1;
                                result         = make_msg(packet_byte, 7'd0, 7'd0, 2'd1,
                                                          KIND_REALTIME, ts);
                                cur_b0_next    = '0;
                                cur_b1_next    = '0;
                                cur_b2_next    = '0;
                                cur_count_next = '0;
                                phase_next     = PH_SYSEX;
                            end
                            else if (packet_byte == SYSEX_END)
                            begin
                                time_high_next = th_adv;
                                prev_low_next  = held_byte_reg;
                                cur_time_next  = ts;
                                in_sysex_next  = 1'b0;
                                cur_kind_next  = KIND_SYSCOM;
                                cur_b0_next    = packet_byte;
                                cur_b1_next    = '0;
                                cur_b2_next    = '0;
                                cur_count_next = 2'd1;
                                emit           = 1'b1;
                                result         = make_msg(packet_byte, 7'd0, 7'd0, 2'd1,
                                                          KIND_SYSCOM, ts);
                                phase_next     = PH_START;
                            end
                            else
                            begin
                                drop_rest_next = 1'b1;
                            end
                        end
                        else
                        begin
                            time_high_next = th_adv;
                            prev_low_next  = held_byte_reg;
                            cur_time_next  = ts;
                            cur_b0_next    = packet_byte;
                            cur_b1_next    = '0;
                            cur_b2_next    = '0;
                            cur_count_next = 2'd1;
                            if (packet_byte >= REALTIME_MIN)
                            begin
                                cur_kind_next = KIND_REALTIME;
                                emit          = 1'b1;
                                result        = make_msg(packet_byte, 7'd0, 7'd0, 2'd1,
                                                         KIND_REALTIME, ts);
                                phase_next    = PH_START;
                            end
                            else if (packet_byte > SYSEX_START)
                            begin
                                cur_kind_next = KIND_SYSCOM;
                                if (sys_len(packet_byte) == 2'd1)
                                begin
                                    emit       = 1'b1;
                                    result     = make_msg(packet_byte, 7'd0, 7'd0, 2'd1,
                                                          KIND_SYSCOM, ts);
                                    phase_next = PH_START;
                                end
                                else
                                begin
                                    phase_next = PH_COLLECT;
                                end
                            end
                            else if (packet_byte < SYSEX_START)
                            begin
                                run_status_next = packet_byte;
                                run_length_next = (hi_nibble == PROG_CHANGE ||
                                                   hi_nibble == CHAN_PRESSURE) ? 2'd2 : 2'd3;
                                cur_kind_next   = KIND_CHANNEL;
                                phase_next      = PH_COLLECT;
                            end
                            else
                            begin
                                in_sysex_next = 1'b1;
                                cur_kind_next = KIND_SYSEX;
                                phase_next    = PH_SYSEX;
                            end
                        end
                    end
                    PH_RUNHELD:
                    begin
                        if (packet_byte[7])
                        begin
                            drop_rest_next = 1'b1;
                        end
                        else
                        begin
                            emit           = 1'b1;
                            result         = make_msg(run_status_reg, held_byte_reg[6:0], 7'd0,
                                                      2'd2, KIND_CHANNEL, cur_time_reg);
                            cur_b0_next    = run_status_reg;
                            cur_b1_next    = held_byte_reg[6:0];
                            cur_b2_next    = '0;
                            cur_count_next = 2'd2;
                            if (cur_kind_reg != KIND_CHANNEL || run_status_reg == 8'd0
                                || in_sysex_reg)
                            begin
                                drop_rest_next = 1'b1;
                            end
                            else if (run_length_reg == 2'd3)
                            begin
                                cur_b1_next = packet_byte[6:0];
                                phase_next  = PH_COLLECT;
                            end
                            else
                            begin
                                held_byte_next = packet_byte;
                            end
                        end
                    end
                    PH_COLLECT:
                    begin
                        if (packet_byte[7] || cur_count_reg == 2'd3)
                        begin
                            drop_rest_next = 1'b1;
                        end
                        else
                        begin
                            cur_b0_next    = nb0;
                            cur_b1_next    = nb1;
                            cur_b2_next    = nb2;
                            cur_count_next = cnt_inc;
                            if (cnt_inc >= target)
                            begin
                                emit       = 1'b1;
                                result     = make_msg(nb0, nb1, nb2, cnt_inc, cur_kind_reg,
                                                      cur_time_reg);
                                phase_next = PH_START;
                            end
                        end
                    end
                    PH_SYSEX:
                    begin
                        if (packet_byte[7])
                        begin
                            if (cur_count_reg != 2'd0)
                            begin
                                emit   = 1'b1;
                                result = make_msg(cur_b0_reg, cur_b1_reg, cur_b2_reg,
                                                  cur_count_reg, KIND_SYSEX, cur_time_reg);
                            end
                            cur_b0_next    = '0;
                            cur_b1_next    = '0;
                            cur_b2_next    = '0;
                            cur_count_next = '0;
                            held_byte_next = packet_byte;
                            phase_next     = PH_TS;
                        end
                        else if (cur_count_reg == 2'd3 || cnt_inc == 2'd3)
                        begin
                            // third byte closes the chunk
                            emit           = 1'b1;
                            result         = make_msg(nb0, nb1, nb2, 2'd3, KIND_SYSEX,
                                                      cur_time_reg);
                            cur_b0_next    = '0;
                            cur_b1_next    = '0;
                            cur_b2_next    = '0;
                            cur_count_next = '0;
                        end
                        else
                        begin
                            cur_b0_next    = nb0;
                            cur_b1_next    = nb1;
                            cur_b2_next    = nb2;
                            cur_count_next = cnt_inc;
                        end
                    end
                    default:
                    begin
                        drop_rest_next = 1'b1;
                    end
                endcase

                // open sysex chunk is flushed at packet end
                if (packet_end && !drop_rest_next && phase_next == PH_SYSEX &&
                    cur_count_next != 2'd0)
                begin
                    emit           = 1'b1;
                    result         = make_msg(cur_b0_next, cur_b1_next, cur_b2_next,
                                              cur_count_next, KIND_SYSEX, cur_time_next);
                    cur_b0_next    = '0;
                    cur_b1_next    = '0;
                    cur_b2_next    = '0;
                    cur_count_next = '0;
                end
            end

            if (packet_end)
            begin
                phase_next     = PH_HEADER;
                drop_rest_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            held_byte_reg  <= '0;
            time_high_reg  <= '0;
            prev_low_reg   <= '0;
            run_status_reg <= '0;
            run_length_reg <= '0;
            cur_b0_reg     <= '0;
            cur_b1_reg     <= '0;
            cur_b2_reg     <= '0;
            cur_count_reg  <= '0;
            cur_kind_reg   <= KIND_CHANNEL;
            cur_time_reg   <= '0;
            in_sysex_reg   <= 1'b0;
            drop_rest_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            time_high_reg  <= time_high_next;
            prev_low_reg   <= prev_low_next;
            run_status_reg <= run_status_next;
            run_length_reg <= run_length_next;
            cur_b0_reg     <= cur_b0_next;
            cur_b1_reg     <= cur_b1_next;
            cur_b2_reg     <= cur_b2_next;
            cur_count_reg  <= cur_count_next;
            cur_kind_reg   <= cur_kind_next;
            cur_time_reg   <= cur_time_next;
            in_sysex_reg   <= in_sysex_next;
            drop_rest_reg  <= drop_rest_next;
        end
    end

`ifndef SYNTHESIS
    a_sysex_flag: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SYSEX |-> in_sysex_reg)
        else $error("sysex phase without sysex flag");

    a_runheld_status: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RUNHELD |-> run_status_reg != 8'd0 && run_length_reg == 2'd2)
        else $error("held running-status byte without a two-byte status");

    a_sysex_chunk_open: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SYSEX |-> cur_count_reg != 2'd3)
        else $error("full sysex chunk not flushed");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        take && packet_end |=> phase_reg == PH_HEADER && !drop_rest_reg)
        else $error("packet end did not rearm header parsing");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 450;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 250;
    localparam int HOLD_AFTER    = 40;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_FIRST,
        ST_START,
        ST_STAMP,
        ST_RUN_HELD,
        ST_COLLECT,
        ST_SYSEX
    } parse_state_t;

    typedef struct packed {
        msg_t word;
        logic last;
    } expected_t;

    // Decoder model plus the queue of messages still owed by the block.
    class msg_scoreboard;
        expected_t    pending[$];
        expected_t    step_out[$];
        int           errors = 0;
        int           checked = 0;
        int           noted = 0;
        int           packets = 0;
        int           kind_seen[4] = '{0, 0, 0, 0};

        parse_state_t state = ST_HEADER;
        logic [7:0]   held = '0;
        logic [12:0]  time_hi = '0;
        logic [7:0]   last_low = '0;
        logic [7:0]   run_stat = '0;
        logic [1:0]   run_len = '0;
        logic [7:0]   cur[3] = '{8'd0, 8'd0, 8'd0};
        logic [1:0]   cur_cnt = '0;
        logic [1:0]   cur_knd = '0;
        logic [12:0]  cur_stamp = '0;
        bit           sysex_open = 0;
        bit           dropping = 0;

        function void clear_state();
            held = '0;
            time_hi = '0;
            last_low = '0;
            run_stat = '0;
            run_len = '0;
            cur = '{8'd0, 8'd0, 8'd0};
            cur_cnt = '0;
            cur_knd = '0;
            cur_stamp = '0;
            sysex_open = 0;
        endfunction

        function logic [1:0] common_len(logic [7:0] s);
            if (s == TIME_CODE_QF || s == SONG_SELECT)
                return 2'd2;
            if (s == SONG_POSITION)
                return 2'd3;
            return 2'd1;
        endfunction

        // low byte smaller than the previous one means the low part wrapped
        function logic [12:0] stamp_of(logic [7:0] low);
            if (last_low > low)
                time_hi = time_hi + 13'd128;
            last_low = low;
            return time_hi | {6'd0, low[6:0]};
        endfunction

        function void emit(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           logic [1:0] len, logic [1:0] kind, logic [12:0] stamp);
            expected_t e;
            e.word.byte_zero = b0;
            e.word.byte_one  = (len >= 2'd2) ? b1[6:0] : 7'd0;
            e.word.byte_two  = (len == 2'd3) ? b2[6:0] : 7'd0;
            e.word.length    = len;
            e.word.kind      = kind;
            e.word.stamp     = stamp;
            e.last           = 1'b0;
            step_out.push_back(e);
        endfunction

        function void set_cur(logic [7:0] b0, logic [7:0] b1, logic [1:0] cnt);
            cur[0] = b0;
            cur[1] = b1;
            cur[2] = 8'd0;
            cur_cnt = cnt;
        endfunction

        function void flush_chunk();
            if (cur_cnt != 2'd0)
                emit(cur[0], cur[1], cur[2], cur_cnt, KIND_SYSEX, cur_stamp);
            set_cur(8'd0, 8'd0, 2'd0);
        endfunction

        function void hold_stamp(logic [7:0] b);
            held = b;
            state = ST_STAMP;
        endfunction

        function void start_data(logic [7:0] b);
            if (cur_knd != KIND_CHANNEL || run_stat == 8'd0 || sysex_open)
            begin
                dropping = 1;
            end
            else if (run_len == 2'd3)
            begin
                set_cur(run_stat, b, 2'd2);
                state = ST_COLLECT;
            end
            else
            begin
                held = b;
                state = ST_RUN_HELD;
            end
        endfunction

        function void after_stamp(logic [7:0] b);
            logic [12:0] rt_stamp;
            if (!b[7])
            begin
                if (run_stat == 8'd0)
                begin
                    dropping = 1;
                    return;
                end
                cur_stamp = stamp_of(held);
                sysex_open = 0;
                cur_knd = KIND_CHANNEL;
                set_cur(run_stat, b, 2'd2);
                if (run_len == 2'd2)
                begin
                    emit(run_stat, b, 8'd0, 2'd2, KIND_CHANNEL, cur_stamp);
                    state = ST_START;
                end
                else
                begin
                    state = ST_COLLECT;
                end
            end
            else if (sysex_open)
            begin
                if (b >= REALTIME_MIN)
                begin
                    rt_stamp = stamp_of(held);
                    emit(b, 8'd0, 8'd0, 2'd1, KIND_REALTIME, rt_stamp);
                    set_cur(8'd0, 8'd0, 2'd0);
                    state = ST_SYSEX;
                end
                else if (b == SYSEX_END)
                begin
                    cur_stamp = stamp_of(held);
                    sysex_open = 0;
                    cur_knd = KIND_SYSCOM;
                    set_cur(b, 8'd0, 2'd1);
                    emit(b, 8'd0, 8'd0, 2'd1, KIND_SYSCOM, cur_stamp);
                    state = ST_START;
                end
                else
                begin
                    dropping = 1;
                end
            end
            else
            begin
                cur_stamp = stamp_of(held);
                set_cur(b, 8'd0, 2'd1);
                if (b >= REALTIME_MIN)
                begin
                    cur_knd = KIND_REALTIME;
                    emit(b, 8'd0, 8'd0, 2'd1, KIND_REALTIME, cur_stamp);
                    state = ST_START;
                end
                else if (b > SYSEX_START)
                begin
                    cur_knd = KIND_SYSCOM;
                    if (common_len(b) == 2'd1)
                    begin
                        emit(b, 8'd0, 8'd0, 2'd1, KIND_SYSCOM, cur_stamp);
                        state = ST_START;
                    end
                    else
                    begin
                        state = ST_COLLECT;
                    end
                end
                else if (b < SYSEX_START)
                begin
                    run_stat = b;
                    run_len = (b[7:4] == PROG_CHANGE || b[7:4] == CHAN_PRESSURE) ? 2'd2 : 2'd3;
                    cur_knd = KIND_CHANNEL;
                    state = ST_COLLECT;
                end
                else
                begin
                    sysex_open = 1;
                    cur_knd = KIND_SYSEX;
                    state = ST_SYSEX;
                end
            end
        endfunction

        // one accepted packet word in, owed messages appended to pending
        function void note_byte(logic [7:0] b, logic last_in);
            logic [1:0] target;
            step_out.delete();
            noted++;
            if (!dropping)
            begin
                case (state)
                    ST_HEADER:
                    begin
                        if (!last_in)
                        begin
                            if (b[7:6] != HEADER_TAG)
                            begin
                                dropping = 1;
                            end
                            else
                            begin
                                clear_state();
                                time_hi = {b[5:0], 7'd0};
                                state = ST_FIRST;
                            end
                        end
                    end
                    ST_FIRST:
                    begin
                        if (!b[7])
                        begin
                            // sysex continued from the previous packet
                            sysex_open = 1;
                            cur_knd = KIND_SYSEX;
                            cur_stamp = time_hi;
                            set_cur(b, 8'd0, 2'd1);
                            state = ST_SYSEX;
                        end
                        else
                        begin
                            hold_stamp(b);
                        end
                    end
                    ST_START:
                    begin
                        if (b[7])
                            hold_stamp(b);
                        else
                            start_data(b);
                    end
                    ST_STAMP:
                    begin
                        after_stamp(b);
                    end
                    ST_RUN_HELD:
                    begin
                        if (b[7])
                        begin
                            dropping = 1;
                        end
                        else
                        begin
                            emit(run_stat, held, 8'd0, 2'd2, KIND_CHANNEL, cur_stamp);
                            set_cur(run_stat, held, 2'd2);
                            start_data(b);
                        end
                    end
                    ST_COLLECT:
                    begin
                        if (b[7] || cur_cnt == 2'd3)
                        begin
                            dropping = 1;
                        end
                        else
                        begin
                            cur[cur_cnt] = b;
                            cur_cnt = cur_cnt + 2'd1;
                            target = (cur_knd == KIND_CHANNEL) ? run_len : common_len(cur[0]);
                            if (cur_cnt >= target)
                            begin
                                emit(cur[0], cur[1], cur[2], cur_cnt, cur_knd, cur_stamp);
                                state = ST_START;
                            end
                        end
                    end
                    ST_SYSEX:
                    begin
                        if (b[7])
                        begin
                            flush_chunk();
                            hold_stamp(b);
                        end
                        else
                        begin
                            if (cur_cnt != 2'd3)
                            begin
                                cur[cur_cnt] = b;
                                cur_cnt = cur_cnt + 2'd1;
                            end
                            if (cur_cnt == 2'd3)
                                flush_chunk();
                        end
                    end
                    default:
                    begin
                        dropping = 1;
                    end
                endcase
                if (last_in && !dropping && state == ST_SYSEX)
                    flush_chunk();
            end
            if (last_in)
            begin
                state = ST_HEADER;
                dropping = 0;
                packets++;
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                pending.push_back(step_out[i]);
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_msg(msg_t got, logic got_last);
            expected_t want;
            if (pending.size() == 0)
            begin
                $error("message with nothing owed: msg_byte_zero 'h%0h msg_kind %0d",
                       got.byte_zero, got.kind);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            kind_seen[got.kind]++;
            compare("msg_byte_zero", want.word.byte_zero, got.byte_zero);
            compare("msg_byte_one", want.word.byte_one, got.byte_one);
            compare("msg_byte_two", want.word.byte_two, got.byte_two);
            compare("msg_length", want.word.length, got.length);
            compare("msg_kind", want.word.kind, got.kind);
            compare("msg_time", want.word.stamp, got.stamp);
            compare("run_last", want.last, got_last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bmpd_pkt_if pkt_bus();
    bmpd_msg_if msg_bus();

    ble_midi_packet_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_bus),
        .msg   (msg_bus)
    );

    msg_scoreboard board;
    logic [7:0]    pkt_q[$];
    logic [6:0]    stamp_low;
    bit            send_burst;
    bit            recv_burst;
    bit            long_hold_done;
    int            hold_left;
    int            recv_gap_left;
    int            cycle_count;
    int            random_bytes;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function logic [7:0] data_byte();
        return 8'($urandom_range(0, 127));
    endfunction

    function logic [7:0] next_stamp();
        stamp_low = stamp_low + 7'($urandom_range(0, 24));
        return {1'b1, stamp_low};
    endfunction

    // mostly well-formed packets with random content, plus some junk
    function void build_random_packet();
        int         n_elem;
        int         n_data;
        int         rt_pos;
        bit         with_rt;
        logic [7:0] status;
        pkt_q.delete();
        stamp_low = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 19) == 0)
            pkt_q.push_back(8'($urandom_range(0, 255)));
        else
            pkt_q.push_back({HEADER_TAG, 6'($urandom_range(0, 63))});
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 5))
                pkt_q.push_back(data_byte());
        end
        n_elem = $urandom_range(0, 6);
        for (int e = 0; e < n_elem; e++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 11:
                begin
                    status = 8'($urandom_range(8'h80, 8'hEF));
                    pkt_q.push_back(next_stamp());
                    pkt_q.push_back(status);
                    pkt_q.push_back(data_byte());
                    if (status[7:4] != PROG_CHANGE && status[7:4] != CHAN_PRESSURE)
                        pkt_q.push_back(data_byte());
                end
                3:
                begin
                    repeat ($urandom_range(1, 2))
                        pkt_q.push_back(data_byte());
                end
                4:
                begin
                    pkt_q.push_back(next_stamp());
                    repeat ($urandom_range(1, 2))
                        pkt_q.push_back(data_byte());
                end
                5:
                begin
                    status = TIME_CODE_QF + 8'($urandom_range(0, 5));
                    pkt_q.push_back(next_stamp());
                    pkt_q.push_back(status);
                    if (status == TIME_CODE_QF || status == SONG_SELECT)
                        pkt_q.push_back(data_byte());
                    else if (status == SONG_POSITION)
                    begin
                        pkt_q.push_back(data_byte());
                        pkt_q.push_back(data_byte());
                    end
                end
                6:
                begin
                    pkt_q.push_back(next_stamp());
                    pkt_q.push_back(8'($urandom_range(REALTIME_MIN, 8'hFF)));
                end
                7, 8:
                begin
                    n_data = $urandom_range(0, 7);
                    with_rt = ($urandom_range(0, 2) == 0);
                    rt_pos = $urandom_range(0, n_data);
                    pkt_q.push_back(next_stamp());
                    pkt_q.push_back(SYSEX_START);
                    for (int i = 0; i <= n_data; i++)
                    begin
                        if (with_rt && i == rt_pos)
                        begin
                            pkt_q.push_back(next_stamp());
                            pkt_q.push_back(8'($urandom_range(REALTIME_MIN, 8'hFF)));
                        end
                        if (i < n_data)
                            pkt_q.push_back(data_byte());
                    end
                    if ($urandom_range(0, 4) != 0)
                    begin
                        pkt_q.push_back(next_stamp());
                        pkt_q.push_back(SYSEX_END);
                    end
                end
                9:
                begin
                    pkt_q.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    pkt_q.push_back(next_stamp());
                end
            endcase
        end
    endfunction

    task send_byte(input logic [7:0] b, input logic last_in);
        int gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            pkt_bus.valid <= 1'b0;
            pkt_bus.packet_byte <= 8'($urandom_range(0, 255));
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pkt_bus.valid <= 1'b1;
        pkt_bus.packet_byte <= b;
        pkt_bus.packet_end <= last_in;
        @(posedge clk);
        while (!pkt_bus.ready)
            @(posedge clk);
        board.note_byte(b, last_in);
    endtask

    task send_packet();
        send_burst = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < pkt_q.size(); i++)
            send_byte(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // receiver: random stalls, plus one long hold-off to back up the block
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0)
                recv_burst = !recv_burst;
            if (hold_left > 0)
            begin
                msg_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (recv_gap_left > 0)
            begin
                msg_bus.ready <= 1'b0;
                recv_gap_left--;
            end
            else
            begin
                msg_bus.ready <= 1'b1;
                recv_gap_left = recv_burst ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : msg_monitor
        msg_t got;
        if (rst_n && msg_bus.valid && msg_bus.ready)
        begin
            got.byte_zero = msg_bus.msg_byte_zero;
            got.byte_one  = msg_bus.msg_byte_one;
            got.byte_two  = msg_bus.msg_byte_two;
            got.length    = msg_bus.msg_length;
            got.kind      = msg_bus.msg_kind;
            got.stamp     = msg_bus.msg_time;
            board.check_msg(got, msg_bus.run_last);
            if (board.checked == HOLD_AFTER && !long_hold_done)
            begin
                long_hold_done = 1;
                hold_left = LONG_HOLD;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout: %0d messages still owed after %0d cycles",
                     board.pending.size(), cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        pkt_bus.valid = 1'b0;
        pkt_bus.packet_byte = 8'd0;
        pkt_bus.packet_end = 1'b0;
        msg_bus.ready = 1'b0;
        send_burst = 0;
        recv_burst = 0;
        long_hold_done = 0;
        hold_left = 0;
        recv_gap_left = 0;
        cycle_count = 0;
        random_bytes = 0;
        stamp_low = '0;
        board = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // header only
        pkt_q = '{8'h80};
        send_packet();
        // bad header drops the packet
        pkt_q = '{8'h00, 8'h90};
        send_packet();
        // full-range bytes, running status, low-byte wrap, lone running byte at the tail
        pkt_q = '{8'hBF, 8'hFF, 8'h90, 8'h7F, 8'h7F, 8'h40, 8'h00,
                  8'h85, 8'hC3, 8'h05, 8'h06};
        send_packet();
        // sysex carried over from the previous packet, real time inside sysex, EOX
        pkt_q = '{8'h80, 8'h12, 8'h34, 8'h56, 8'h78, 8'h81, 8'hF8, 8'h01, 8'h82, 8'hF7};
        send_packet();
        // data after a timestamp in sysex with a running status: ends the sysex
        pkt_q = '{8'h81, 8'h80, 8'hE0, 8'h01, 8'h02, 8'h80, 8'hF0, 8'h03,
                  8'h81, 8'h04, 8'h05};
        send_packet();

        while (random_bytes < RANDOM_BYTES)
        begin
            build_random_packet();
            random_bytes += pkt_q.size();
            send_packet();
        end
        @(negedge clk);
        pkt_bus.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d packet words in %0d packets; %0d messages checked.",
                 board.noted, board.packets, board.checked);
        $display("Kinds seen: channel %0d, system common %0d, real time %0d, sysex %0d.",
                 board.kind_seen[KIND_CHANNEL], board.kind_seen[KIND_SYSCOM],
                 board.kind_seen[KIND_REALTIME], board.kind_seen[KIND_SYSEX]);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
